### src/gcd_pkg.sv
// Shared constants, datapath type and CORDIC angle table for the great-circle distance block.
`default_nettype none

package gcd_pkg;

  // Fixed-point format of every angle and trig value.
  localparam int FRAC_BITS = 32;
  // Number of CORDIC micro-rotations per unit.
  localparam int ITERS = 32;
  // Signed width of the CORDIC datapath.
  localparam int DW = 40;
  // Width of nonnegative trig magnitudes.
  localparam int MAG_W = FRAC_BITS + 2;
  // Result bits produced by the square-root pipeline.
  localparam int ROOT_W = FRAC_BITS + 2;

  typedef logic signed [DW-1:0] dp_t;

  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic [31:0] FULL_TURN = 32'd3600000000;
  localparam logic [31:0] DIST_MAX = 32'd2199114858;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  // Pi in Q61, split for two narrow multipliers.
  localparam logic [62:0] PI_Q61 = 63'h6487ED5110B4611A;
  localparam logic [31:0] PI_LO = PI_Q61[31:0];
  localparam logic [30:0] PI_HI = PI_Q61[62:32];

  // Reciprocal of the full turn, scaled by 2^68, for the degree to radian quotient.
  localparam logic [127:0] RECIP_FULL = (128'd1 << 68) / 128'd3600000000;
  localparam logic [36:0] RAD_RECIP = RECIP_FULL[36:0];

  // CORDIC gain compensation as the start value of a rotation.
  localparam logic [127:0] GAIN_FULL =
    (128'd607252935008881256 << FRAC_BITS) / 128'd1000000000000000000;
  localparam dp_t GAIN_Q = dp_t'(GAIN_FULL);

  // Floor quotient of two nonnegative values by restoring shift and subtract.
  function automatic longint quot_floor(input longint num, input longint den);
    longint q;
    longint rem;
    q = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        q = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q(FRAC_BITS), built from a truncated series in Q62.
  function automatic dp_t atan_q(input int i);
    longint t;
    longint term;
    int k;
    int sh;
    t = 0;
    if (i == 0) begin
      t = 64'sh3243F6A8885A308D;
    end else begin
      for (k = 0; k < 32; k++) begin
        sh = 62 - i * (2 * k + 1);
        if (sh >= 0) begin
          term = quot_floor(longint'(64'd1 << sh), longint'(2 * k + 1));
          t = k[0] ? t - term : t + term;
        end
      end
    end
    return dp_t'((t + (64'sd1 <<< (61 - FRAC_BITS))) >>> (62 - FRAC_BITS));
  endfunction

endpackage

`default_nettype wire

### src/great_circle_distance_top.sv
// Great-circle distance between two points, fully pipelined fixed-point datapath.
// Throughput: one beat per cycle; the pipeline only holds while a finished output
// beat waits and the last pipeline stage is occupied.
// Reset (rst, synchronous): clears all valid bits and sets earth_radius_m to 6371000.
`default_nettype none

module great_circle_distance_top
  import gcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic        [22:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] first_lon,
  input  logic signed [30:0] first_lat,
  input  logic signed [31:0] second_lon,
  input  logic signed [30:0] second_lat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [31:0] distance_cm
);

  // Pipeline depth up to and including the final product register:
  // input prep, five radian stages, rotation, clamp/product, square root,
  // two scaling stages, two vectoring passes and the radius product.
  localparam int DEPTH = 1 + 5 + ITERS + 1 + ROOT_W + 2 + 2 * ITERS + 1;
  localparam int LANES = 5;

  // Lane assignment of the five angle conversions.
  localparam int L_C1 = 0;
  localparam int L_C2 = 1;
  localparam int L_SA = 2;
  localparam int L_SP = 3;
  localparam int L_DL = 4;

  // Configuration. The radius in centimetres follows the register in the next cycle,
  // long before any beat can reach the final product.
  logic [22:0] earth_radius_m;
  logic [29:0] radius_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius_m <= RADIUS_RESET;
    end else if (cfg_we) begin
      earth_radius_m <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    radius_cm <= 30'(earth_radius_m) * 30'd100;
  end

  // Flow control. The whole pipeline moves as one; it may also move while the
  // output beat waits, as long as the last stage holds no item.
  logic             o_load;
  logic             adv;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] same;

  assign o_load   = !out_valid || out_ready;
  assign adv      = o_load || !vld[DEPTH-1];
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Identical points are flagged up front and force a zero distance at the end.
  always_ff @(posedge clk) begin
    if (adv) begin
      same <= {same[DEPTH-2:0],
               (first_lon == second_lon) && (first_lat == second_lat)};
    end
  end

  // Input preparation: clamp latitudes, wrap the longitude difference into
  // (-180, 180] degrees, and form the five doubled half-angles.
  logic signed [31:0] lat1_ext;
  logic signed [31:0] lat2_ext;
  logic signed [31:0] lat1_c;
  logic signed [31:0] lat2_c;
  logic signed [33:0] dlon_raw;
  logic signed [33:0] dlon_w;
  logic signed [31:0] u [LANES];

  always_comb begin
    lat1_ext = 32'(first_lat);
    lat2_ext = 32'(second_lat);
    if (lat1_ext > LAT_MAX) lat1_c = LAT_MAX;
    else if (lat1_ext < -LAT_MAX) lat1_c = -LAT_MAX;
    else lat1_c = lat1_ext;
    if (lat2_ext > LAT_MAX) lat2_c = LAT_MAX;
    else if (lat2_ext < -LAT_MAX) lat2_c = -LAT_MAX;
    else lat2_c = lat2_ext;

    dlon_raw = 34'(second_lon) - 34'(first_lon);
    if (dlon_raw > 34'sd1800000000) dlon_w = dlon_raw - 34'sd3600000000;
    else if (dlon_raw <= -34'sd1800000000) dlon_w = dlon_raw + 34'sd3600000000;
    else dlon_w = dlon_raw;

    u[L_C1] = lat1_c <<< 1;
    u[L_C2] = lat2_c <<< 1;
    u[L_SA] = lat2_c - lat1_c;
    u[L_SP] = lat1_c + lat2_c;
    u[L_DL] = 32'(dlon_w);
  end

  // Degree to radian conversion, one lane per angle. Each lane computes
  // floor((a*pi_q61 + T*2^28) / (T*2^29)) with T the full turn: the quotient
  // is estimated with a reciprocal and then corrected by at most two.
  dp_t rad [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_rad
    localparam logic [95:0] BIAS = 96'(FULL_TURN) << 28;
    localparam logic [96:0] E1 = 97'(FULL_TURN) << 29;
    localparam logic [96:0] E2 = 97'(FULL_TURN) << 30;

    logic        s0_neg, r1_neg, r2_neg, r3_neg, r4_neg;
    logic [30:0] s0_mag;
    logic [62:0] r1_lo;
    logic [62:0] r1_hi;
    logic [95:0] r2_n, r3_n, r4_n;
    logic [73:0] r3_prod;
    logic [35:0] r3_qe, r4_qe;
    logic [67:0] r4_qd;
    logic [96:0] r5_rem;
    logic [35:0] r5_q;

    assign r3_prod = 74'(r2_n[95:59]) * 74'(RAD_RECIP);
    assign r5_rem  = 97'(r4_n) - (97'(r4_qd) << 29);

    always_comb begin
      r5_q = r4_qe;
      if (r5_rem >= E2) r5_q = r4_qe + 36'd2;
      else if (r5_rem >= E1) r5_q = r4_qe + 36'd1;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s0_neg <= u[l][31];
        s0_mag <= u[l][31] ? 31'(-u[l]) : 31'(u[l]);

        r1_neg <= s0_neg;
        r1_lo  <= 63'(s0_mag) * 63'(PI_LO);
        r1_hi  <= 63'(s0_mag) * 63'(PI_HI);

        r2_neg <= r1_neg;
        r2_n   <= (96'(r1_hi) << 32) + 96'(r1_lo) + BIAS;

        r3_neg <= r2_neg;
        r3_n   <= r2_n;
        r3_qe  <= r3_prod[73:38];

        r4_neg <= r3_neg;
        r4_n   <= r3_n;
        r4_qe  <= r3_qe;
        r4_qd  <= 68'(r3_qe) * 68'(FULL_TURN);

        rad[l] <= r4_neg ? -dp_t'(r5_q) : dp_t'(r5_q);
      end
    end
  end

  // Sine and cosine by rotation, all five lanes side by side.
  dp_t rx [LANES];
  dp_t ry [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_rot
    gcd_cordic #(.VECTORING(1'b0)) u_rot (
      .clk   (clk),
      .en    (adv),
      .x_in  (GAIN_Q),
      .y_in  ('0),
      .z_in  (rad[l]),
      .x_out (rx[l]),
      .y_out (ry[l]),
      .z_out ()
    );
  end

  // Clamp both latitude cosines at zero, take their product and the magnitudes
  // of the remaining sines and cosines.
  logic [MAG_W-1:0]   c1_c, c2_c;
  logic [2*MAG_W-1:0] p1_prod;
  logic [MAG_W-1:0]   p1_sa, p1_sp, p1_cd, p1_sd;

  assign c1_c = rx[L_C1][DW-1] ? '0 : rx[L_C1][MAG_W-1:0];
  assign c2_c = rx[L_C2][DW-1] ? '0 : rx[L_C2][MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_prod <= (2*MAG_W)'(c1_c) * (2*MAG_W)'(c2_c);
      p1_sa   <= MAG_W'(ry[L_SA][DW-1] ? -ry[L_SA] : ry[L_SA]);
      p1_sp   <= MAG_W'(ry[L_SP][DW-1] ? -ry[L_SP] : ry[L_SP]);
      p1_cd   <= MAG_W'(rx[L_DL][DW-1] ? -rx[L_DL] : rx[L_DL]);
      p1_sd   <= MAG_W'(ry[L_DL][DW-1] ? -ry[L_DL] : ry[L_DL]);
    end
  end

  // Floor square root of the cosine product, one result bit per stage.
  logic [2*MAG_W-1:0] sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root [ROOT_W+1];
  logic [MAG_W-1:0]   sq_sa   [ROOT_W+1];
  logic [MAG_W-1:0]   sq_sp   [ROOT_W+1];
  logic [MAG_W-1:0]   sq_cd   [ROOT_W+1];
  logic [MAG_W-1:0]   sq_sd   [ROOT_W+1];

  assign sq_rem[0]  = p1_prod;
  assign sq_root[0] = '0;
  assign sq_sa[0]   = p1_sa;
  assign sq_sp[0]   = p1_sp;
  assign sq_cd[0]   = p1_cd;
  assign sq_sd[0]   = p1_sd;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - j;
    logic [2*MAG_W+1:0] trial;
    logic               take;

    // (root + 2^B)^2 - root^2
    assign trial = ((2*MAG_W+2)'(sq_root[j]) << (B + 1)) + ((2*MAG_W+2)'(1) << (2 * B));
    assign take  = (2*MAG_W+2)'(sq_rem[j]) >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[j+1]  <= take ? (2*MAG_W)'((2*MAG_W+2)'(sq_rem[j]) - trial) : sq_rem[j];
        sq_root[j+1] <= take ? (sq_root[j] | (ROOT_W'(1) << B)) : sq_root[j];
        sq_sa[j+1]   <= sq_sa[j];
        sq_sp[j+1]   <= sq_sp[j];
        sq_cd[j+1]   <= sq_cd[j];
        sq_sd[j+1]   <= sq_sd[j];
      end
    end
  end

  // Scale the longitude sine and cosine by g, rounded half up.
  localparam logic [2*MAG_W:0] HALF_LSB = (2*MAG_W+1)'(1) << (FRAC_BITS - 1);

  logic [2*MAG_W-1:0] m1_b, m1_q;
  logic [MAG_W-1:0]   m1_sa, m1_sp;
  logic [2*MAG_W:0]   m1_b_rnd, m1_q_rnd;
  dp_t                m2_b, m2_q, m2_sa, m2_sp;

  assign m1_b_rnd = (2*MAG_W+1)'(m1_b) + HALF_LSB;
  assign m1_q_rnd = (2*MAG_W+1)'(m1_q) + HALF_LSB;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_b  <= (2*MAG_W)'(sq_root[ROOT_W]) * (2*MAG_W)'(sq_sd[ROOT_W]);
      m1_q  <= (2*MAG_W)'(sq_root[ROOT_W]) * (2*MAG_W)'(sq_cd[ROOT_W]);
      m1_sa <= sq_sa[ROOT_W];
      m1_sp <= sq_sp[ROOT_W];

      m2_b  <= dp_t'(m1_b_rnd >> FRAC_BITS);
      m2_q  <= dp_t'(m1_q_rnd >> FRAC_BITS);
      m2_sa <= dp_t'(m1_sa);
      m2_sp <= dp_t'(m1_sp);
    end
  end

  // The two vector magnitudes m and n, then the central half-angle atan2(m, n).
  dp_t mm, nn, half_ang;

  gcd_cordic #(.VECTORING(1'b1)) u_vec_m (
    .clk   (clk),
    .en    (adv),
    .x_in  (m2_sa),
    .y_in  (m2_b),
    .z_in  ('0),
    .x_out (mm),
    .y_out (),
    .z_out ()
  );

  gcd_cordic #(.VECTORING(1'b1)) u_vec_n (
    .clk   (clk),
    .en    (adv),
    .x_in  (m2_sp),
    .y_in  (m2_q),
    .z_in  ('0),
    .x_out (nn),
    .y_out (),
    .z_out ()
  );

  gcd_cordic #(.VECTORING(1'b1)) u_vec_ang (
    .clk   (clk),
    .en    (adv),
    .x_in  (nn),
    .y_in  (mm),
    .z_in  ('0),
    .x_out (),
    .y_out (),
    .z_out (half_ang)
  );

  // Central angle times the radius in centimetres.
  logic [34:0] theta;
  logic [64:0] f1_prod;

  assign theta = half_ang[DW-1] ? '0 : {half_ang[33:0], 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_prod <= 65'(theta) * 65'(radius_cm);
    end
  end

  // Round half up, saturate, and hold the beat in the output register.
  logic [65:0] f_rnd;
  logic [33:0] f_res;
  logic [31:0] f_dist;

  assign f_rnd  = 66'(f1_prod) + (66'(1) << (FRAC_BITS - 1));
  assign f_res  = f_rnd[65:32];
  assign f_dist = same[DEPTH-1] ? '0 :
                  (f_res > 34'(DIST_MAX)) ? DIST_MAX : f_res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      distance_cm <= f_dist;
    end
  end

  // A delivered distance never exceeds the saturation limit.
  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_cm <= DIST_MAX)
    else $error("distance above saturation limit");

  // Input back-pressure only arises with a waiting output and a full last stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && vld[DEPTH-1])
    else $error("input stalled without a blocked output");

  // A beat in the last stage that is held back is still there in the next cycle.
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    vld[DEPTH-1] && !o_load |=> vld[DEPTH-1])
    else $error("item lost from the last pipeline stage");

  // Reset leaves no output beat pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat valid right after reset");

endmodule

`default_nettype wire

### src/gcd_cordic.sv
// Pipelined CORDIC unit, one register stage per micro-rotation, rotation or vectoring mode.
`default_nettype none

module gcd_cordic
  import gcd_pkg::*;
#(
  parameter bit VECTORING = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  dp_t  x_in,
  input  dp_t  y_in,
  input  dp_t  z_in,
  output dp_t  x_out,
  output dp_t  y_out,
  output dp_t  z_out
);

  dp_t xs [ITERS+1];
  dp_t ys [ITERS+1];
  dp_t zs [ITERS+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;

  for (genvar i = 0; i < ITERS; i++) begin : g_step
    localparam dp_t ANG = atan_q(i);
    dp_t dx;
    dp_t dy;
    logic cw;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    // Rotation follows the residual angle, vectoring drives y toward zero.
    assign cw = VECTORING ? ys[i][DW-1] : !zs[i][DW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if (cw) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - ANG;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + ANG;
        end
      end
    end
  end

  assign x_out = xs[ITERS];
  assign y_out = ys[ITERS];
  assign z_out = zs[ITERS];

endmodule

`default_nettype wire

### bench/great_circle_distance_top_tb.sv
// Self-checking testbench for the great-circle distance pipeline.
`timescale 1ns / 1ps

module great_circle_distance_top_tb;
  import gcd_pkg::*;

  localparam int CORDIC_STEPS = 32;
  localparam int QBITS = 32;
  // Beyond the pipeline latency, with some margin.
  localparam int PIPE_SETTLE = 200;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic        [22:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] first_lon;
  logic signed [30:0] first_lat;
  logic signed [31:0] second_lon;
  logic signed [30:0] second_lat;
  logic               out_valid;
  logic               out_ready;
  logic        [31:0] distance_cm;

  great_circle_distance_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .first_lon   (first_lon),
    .first_lat   (first_lat),
    .second_lon  (second_lon),
    .second_lat  (second_lat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance_cm (distance_cm)
  );

  // Our own copy of the radius register, the arctangent table and the CORDIC gain.
  logic [22:0] radius_m;
  longint      atan_tab [CORDIC_STEPS];
  longint      cordic_gain;

  // Distances still owed by the block, oldest first.
  logic [31:0] distance_queue [$];

  int  mismatches;
  int  beats_sent;
  int  beats_checked;
  int  radius_settings;
  bit  idle_on;
  int  ready_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run ends here if the pipeline never drains.
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Distance predictor. Angles are held in Q32 radians, every CORDIC shift is an
  // arithmetic one, and wide products are done in 128 bits so that nothing wraps.
  // ---------------------------------------------------------------------------

  // Builds atan(2^-i) from a truncated Taylor series in Q62, then rounds to Q32.
  // The CORDIC start value is the gain constant taken to Q32 by a floor division.
  task automatic build_cordic_consts();
    longint acc;
    longint term;
    int     sh;
    logic [127:0] g;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = 64'sh3243F6A8885A308D;
      end else begin
        for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
          sh = 62 - i * (2 * k + 1);
          term = longint'(64'd1 << sh) / longint'(2 * k + 1);
          acc = k[0] ? acc - term : acc + term;
        end
      end
      atan_tab[i] = (acc + (64'sd1 <<< (61 - QBITS))) >>> (62 - QBITS);
    end
    g = (128'd607252935008881256 << QBITS) / 128'd1000000000000000000;
    cordic_gain = longint'(g[63:0]);
  endtask

  // Angle in units of 0.5e-7 degree (a doubled coordinate) to Q32 radians.
  function automatic longint to_radians(longint u);
    longint       a;
    logic [127:0] p;
    logic [63:0]  q;
    logic [63:0]  r;
    a = (u < 0) ? -u : u;
    p = (128'(a) * 128'(PI_Q61)) / 128'd3600000000;
    q = p[63:0];
    r = (q + (64'd1 << 28)) >> 29;
    return (u < 0) ? -longint'(r) : longint'(r);
  endfunction

  task automatic cordic_rotate(input longint angle, output longint cos_v, output longint sin_v);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = cordic_gain;
    y = 0;
    z = angle;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    cos_v = x;
    sin_v = y;
  endtask

  // Vectoring mode: x must be nonnegative; gives the scaled length and atan2(y, x).
  task automatic cordic_vector(input longint x_in, input longint y_in,
                               output longint len, output longint angle);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = x_in;
    y = y_in;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    len = x;
    angle = z;
  endtask

  // Product of two nonnegative Q32 values, rounded half up.
  function automatic longint mul_q32(longint a, longint b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (QBITS - 1));
    p = p >> QBITS;
    return longint'(p[63:0]);
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_latitude(longint v);
    if (v > longint'(LAT_MAX)) return longint'(LAT_MAX);
    if (v < -longint'(LAT_MAX)) return -longint'(LAT_MAX);
    return v;
  endfunction

  task automatic predict_distance(input logic signed [31:0] lon_a, input logic signed [30:0] lat_a,
                                  input logic signed [31:0] lon_b, input logic signed [30:0] lat_b,
                                  output logic [31:0] dist_cm);
    longint lat1, lat2, dlon;
    longint c1, c2, sa, sp, cd, sd, unused, m_len, n_len, z;
    longint g, b, q;
    logic [127:0] prod;
    logic [63:0]  theta;
    logic [63:0]  res;
    // The very same raw coordinates are defined to be exactly zero apart.
    if (lon_a == lon_b && lat_a == lat_b) begin
      dist_cm = '0;
      return;
    end
    lat1 = clamp_latitude(longint'(lat_a));
    lat2 = clamp_latitude(longint'(lat_b));
    dlon = longint'(lon_b) - longint'(lon_a);
    // Only a single wrap toward (-180, 180] degrees, even for wild longitudes.
    if (dlon > 64'sd1800000000) dlon -= 64'sd3600000000;
    if (dlon <= -64'sd1800000000) dlon += 64'sd3600000000;

    cordic_rotate(to_radians(2 * lat1), c1, unused);
    cordic_rotate(to_radians(2 * lat2), c2, unused);
    cordic_rotate(to_radians(lat2 - lat1), unused, sa);
    cordic_rotate(to_radians(lat1 + lat2), unused, sp);
    cordic_rotate(to_radians(dlon), cd, sd);
    if (c1 < 0) c1 = 0;
    if (c2 < 0) c2 = 0;

    // g is the floor square root of the Q64 product cos(lat1) * cos(lat2), giving g in Q32.
    prod = 128'(c1) * 128'(c2);
    g = 0;
    for (int bit_i = QBITS + 1; bit_i >= 0; bit_i--) begin
      longint t;
      t = g | (64'sd1 <<< bit_i);
      if (128'(t) * 128'(t) <= prod) g = t;
    end
    b = mul_q32(g, abs64(sd));
    q = mul_q32(g, abs64(cd));

    cordic_vector(abs64(sa), b, m_len, unused);
    cordic_vector(abs64(sp), q, n_len, unused);
    cordic_vector(n_len, m_len, unused, z);
    if (z < 0) z = 0;
    theta = 64'(z) << 1;

    prod = 128'(theta) * 128'({41'd0, radius_m} * 64'd100) + (128'd1 << (QBITS - 1));
    if (prod[127:96] != '0) begin
      res = 64'(DIST_MAX);
    end else begin
      res = prod[95:32];
      if (res > 64'(DIST_MAX)) res = 64'(DIST_MAX);
    end
    dist_cm = res[31:0];
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every output beat is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (distance_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: distance_cm=%0d", distance_cm);
      end else begin
        logic [31:0] want;
        want = distance_queue.pop_front();
        beats_checked++;
        if (distance_cm !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch on beat %0d: expected %0d, got %0d",
                     beats_checked, want, distance_cm);
        end
      end
    end
  end

  // Receiver side. A long hold requested by a test comes first; otherwise short
  // random stalls while idling is enabled.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        repeat (ready_hold) @(posedge clk);
        ready_hold = 0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register helpers. All of them are entered right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offers one coordinate pair and returns at the edge where the beat is taken.
  task automatic send_pair(input logic signed [31:0] lon_a, input logic signed [30:0] lat_a,
                           input logic signed [31:0] lon_b, input logic signed [30:0] lat_b);
    logic [31:0] want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    first_lon  <= lon_a;
    first_lat  <= lat_a;
    second_lon <= lon_b;
    second_lat <= lat_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_distance(lon_a, lat_a, lon_b, lat_b, want);
    distance_queue.push_back(want);
    beats_sent++;
  endtask

  // Same as send_pair, for coordinates written as plain numbers.
  task automatic send_coords(input longint lon_a, input longint lat_a,
                             input longint lon_b, input longint lat_b);
    send_pair(32'(lon_a), 31'(lat_a), 32'(lon_b), 31'(lat_b));
  endtask

  // Stops offering beats and waits until the pipeline is empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_radius(input logic [22:0] value);
    drain_pipeline();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    radius_m = value;
    radius_settings++;
  endtask

  function automatic logic signed [31:0] rand_lon(bit wild);
    if (wild) return $urandom;
    return 32'(longint'($urandom_range(0, 3600000000)) - 64'sd1800000000);
  endfunction

  function automatic logic signed [30:0] rand_lat(bit wild);
    if (wild) return 31'($urandom);
    return 31'(longint'($urandom_range(0, 1800000000)) - 64'sd900000000);
  endfunction

  // Mostly well-formed coordinates, with a share of full-width values that push
  // latitudes into saturation and longitudes past the single wrap.
  task automatic send_random(int count);
    logic signed [31:0] la;
    logic signed [30:0] pa;
    for (int n = 0; n < count; n++) begin
      la = rand_lon($urandom_range(0, 9) == 0);
      pa = rand_lat($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 15))
        0:       send_pair(la, pa, la, pa);
        1:       send_pair(la, pa, la + 32'($urandom_range(0, 40)) - 32'd20,
                           pa + 31'($urandom_range(0, 40)) - 31'd20);
        2:       send_pair(la, pa, 32'(longint'(la) + 64'sd1800000000), -pa);
        default: send_pair(la, pa, rand_lon($urandom_range(0, 9) == 0),
                           rand_lat($urandom_range(0, 9) == 0));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, poles, antipodes, identical points and the wrap of the
  // longitude difference, all at the reset radius.
  task automatic test_directed();
    send_coords(0, 0, 0, 0);
    send_coords(32'sh7FFFFFFF, 31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh3FFFFFFF);
    send_coords(32'sh80000000, 31'sh40000000, 32'sh80000000, 31'sh40000000);
    send_coords(0, 900000000, 0, -900000000);
    send_coords(0, 0, 1800000000, 0);
    send_coords(-1800000000, 0, 1800000000, 0);
    send_coords(0, 0, -1800000000, 0);
    send_coords(32'sh80000000, 0, 32'sh7FFFFFFF, 0);
    send_coords(32'sh7FFFFFFF, 31'sh3FFFFFFF, 32'sh80000000, 31'sh40000000);
    // Out-of-range latitudes that saturate to the same pole but differ in raw bits.
    send_coords(0, 31'sh3FFFFFFF, 0, 900000000);
    send_coords(100, 31'sh40000000, -100, -900000001);
    send_coords(0, 0, 1, 0);
    send_coords(0, 0, 0, 1);
    send_coords(1799999999, 0, -1799999999, 0);
    send_coords(900000000, 450000000, -900000000, -450000000);
    send_coords(0, 899999999, 1800000000, 899999999);
    send_coords(-1, -1, 0, 0);
    send_coords(1234567, -7654321, -1800000000, 900000000);
    send_coords(32'sh55555555, 31'sh2AAAAAAA, 32'shAAAAAAAA, 31'sh55555555);
    send_coords(0, 0, 900000000, 0);
  endtask

  // Six radius settings, including both ends of the legal range and the full
  // register width, where long distances saturate.
  task automatic test_radius_sweep();
    logic [22:0] radii [6];
    radii = '{23'd7000000, 23'd6000000, 23'h7FFFFF, 23'd0, 23'd6371000, 23'd0};
    radii[5] = 23'($urandom_range(6000000, 7000000));
    foreach (radii[i]) begin
      write_radius(radii[i]);
      send_coords(0, 0, 1800000000, 0);
      send_coords(0, 900000000, 0, -900000000);
      send_random(180);
    end
  endtask

  // The receiver holds off far longer than the pipeline is deep while beats
  // keep coming, so the input side must stall; then the sender waits it out.
  task automatic test_backpressure();
    drain_pipeline();
    ready_hold = 400;
    send_random(250);
    drain_pipeline();
  endtask

  // Bulk traffic with random gaps on both sides.
  task automatic test_random_traffic();
    send_random(100);
  endtask

  // Back-to-back beats with no idling at all.
  task automatic test_streaming();
    drain_pipeline();
    idle_on = 1'b0;
    send_random(200);
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    first_lon  = '0;
    first_lat  = '0;
    second_lon = '0;
    second_lat = '0;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    radius_settings = 0;
    ready_hold = 0;
    idle_on = 1'b1;
    radius_m = RADIUS_RESET;
    build_cordic_consts();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_radius_sweep();
    test_backpressure();
    test_random_traffic();
    test_streaming();
    drain_pipeline();

    $display("checked %0d of %0d distance beats over %0d radius settings,", beats_checked,
             beats_sent, radius_settings + 1);
    $display("with random stalls, a long output hold and a gap-free stream at the end");
    if (mismatches == 0 && beats_checked == beats_sent) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
